// ===== rtl/core/kptl_pkg.sv =====
// ----------------------------------------------------------------------------
// kptl_pkg
// Shared types and constants of the key peer table lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package kptl_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int MAX_PEERS_DEF     = 8;
    localparam int MAX_PREDICTIONS   = 2;
    localparam int CMD_QUEUE_DEPTH   = 2;
    localparam int RES_QUEUE_DEPTH   = 2;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_PEER   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_NEW_ENTRY  = 3'd0,
        ST_PEER_ADDED = 3'd1,
        ST_DUPLICATE  = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_PEERS_FULL = 3'd4,
        ST_ZERO_KEY   = 3'd5
    } t_status;

    typedef enum logic {
        FUNC_REGISTER = 1'b0,
        FUNC_LOOKUP   = 1'b1
    } t_func;

    typedef struct packed {
        t_func       func;
        logic [63:0] key;
        logic [31:0] peer;
        logic        peer_given;
        logic [31:0] sender;
    } t_req;

    typedef struct packed {
        t_kind       kind;
        t_status     status;
        logic [1:0]  group;
        logic [63:0] key_out;
        logic [31:0] peer_out;
        logic [3:0]  peer_count;
        logic        last;
    } t_res;

    typedef struct packed {
        t_func       func;
        logic        zero_key;
        logic [63:0] key;
        logic [31:0] addr;
        logic [31:0] sender;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/core/kptl_ram.sv =====
// ----------------------------------------------------------------------------
// kptl_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module kptl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/kptl_fifo.sv =====
// ----------------------------------------------------------------------------
// kptl_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module kptl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_slot[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/kptl_front.sv =====
// ----------------------------------------------------------------------------
// kptl_front
// Accepts requests, resolves the address to register and flags a zero key,
// and queues the classified command for the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module kptl_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire kptl_pkg::t_req i_req,
    output logic               o_full,
    input  wire logic          i_cmd_pop,
    output kptl_pkg::t_cmd     o_cmd,
    output logic               o_cmd_empty
);

    kptl_pkg::t_cmd cmd;

    always_comb begin
        cmd.func     = i_req.func;
        cmd.zero_key = (i_req.key == 64'd0);
        cmd.key      = i_req.key;
        cmd.addr     = i_req.peer_given ? i_req.peer : i_req.sender;
        cmd.sender   = i_req.sender;
    end

    kptl_fifo #(
        .WIDTH ($bits(kptl_pkg::t_cmd)),
        .DEPTH (kptl_pkg::CMD_QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (o_cmd_empty)
    );

endmodule

`default_nettype wire

// ===== rtl/core/kptl_back.sv =====
// ----------------------------------------------------------------------------
// kptl_back
// Table engine: scans the key store, checks or walks peer lists, updates the
// tables and writes results into the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module kptl_back #(
    parameter int TABLE_ENTRIES = kptl_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_PEERS     = kptl_pkg::MAX_PEERS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_wdata,
    input  wire kptl_pkg::t_cmd i_cmd,
    input  wire logic           i_cmd_empty,
    output logic                o_cmd_pop,
    output kptl_pkg::t_res      o_res,
    output logic                o_empty,
    input  wire logic           i_pop
);

    localparam int IW  = $clog2(TABLE_ENTRIES);
    localparam int FW  = $clog2(TABLE_ENTRIES + 1);
    localparam int CW  = $clog2(MAX_PEERS + 1);
    localparam int PD  = TABLE_ENTRIES * MAX_PEERS;
    localparam int PAW = $clog2(PD);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_SRCH  = 12'b0000_0000_0010,
        S_RREAD = 12'b0000_0000_0100,
        S_RCAP  = 12'b0000_0000_1000,
        S_CRD   = 12'b0000_0001_0000,
        S_CCMP  = 12'b0000_0010_0000,
        S_SDONE = 12'b0000_0100_0000,
        S_HDR   = 12'b0000_1000_0000,
        S_PRD   = 12'b0001_0000_0000,
        S_PEM   = 12'b0010_0000_0000,
        S_NEXTG = 12'b0100_0000_0000,
        S_OUT1  = 12'b1000_0000_0000
    } t_state;

    t_state         r_state, n_state;
    kptl_pkg::t_cmd r_cmd, n_cmd;
    kptl_pkg::t_res r_res, n_res;
    logic [FW-1:0]  r_fill, n_fill;
    logic [1:0]     r_pc;
    logic [FW-1:0]  r_i, n_i;
    logic           r_pend, n_pend;
    logic [IW-1:0]  r_pidx, n_pidx;
    logic [IW-1:0]  r_ent, n_ent;
    logic [1:0]     r_g, n_g;
    logic [1:0]     r_want, n_want;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [CW-1:0]  r_k, n_k;
    logic [CW-1:0]  r_match, n_match;
    logic [CW-1:0]  r_emit, n_emit;
    logic [63:0]    r_gkey, n_gkey;

    logic           key_we, key_re;
    logic [IW-1:0]  key_waddr, key_raddr;
    logic [63:0]    key_rdata;
    logic           cnt_we, cnt_re;
    logic [IW-1:0]  cnt_waddr;
    logic [CW-1:0]  cnt_wdata, cnt_rdata;
    logic           peer_we, peer_re;
    logic [PAW-1:0] peer_waddr, peer_raddr;
    logic [31:0]    peer_wdata, peer_rdata;

    logic           res_push, res_full;
    kptl_pkg::t_res res_data;

    logic           match;
    logic [CW-1:0]  kept;
    logic           last_grp;
    logic [1:0]     sat_pc, want;
    logic [FW-1:0]  fill_m1;
    logic [IW-1:0]  next_ent;
    logic [31:0]    cmp_val;
    logic           skip;

    assign match    = r_pend && (key_rdata == r_cmd.key);
    assign kept     = r_cnt - r_match;
    assign last_grp = (r_g == r_want);
    assign sat_pc   = (32'(r_pc) > 32'(kptl_pkg::MAX_PREDICTIONS)) ?
                      2'(kptl_pkg::MAX_PREDICTIONS) : r_pc;
    assign fill_m1  = r_fill - 1'b1;
    assign want     = (FW'(sat_pc) > fill_m1) ? fill_m1[1:0] : sat_pc;
    assign next_ent = ((FW'(r_ent) + 1'b1) == r_fill) ? '0 : r_ent + 1'b1;
    assign cmp_val  = (r_cmd.func == kptl_pkg::FUNC_LOOKUP) ? r_cmd.sender : r_cmd.addr;
    assign skip     = (peer_rdata == r_cmd.sender);
    assign key_raddr  = (r_state == S_SRCH) ? r_i[IW-1:0] : r_ent;
    assign peer_raddr = PAW'(r_ent) * PAW'(MAX_PEERS) + PAW'(r_k);

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_res    = r_res;
        n_fill   = r_fill;
        n_i      = r_i;
        n_pend   = r_pend;
        n_pidx   = r_pidx;
        n_ent    = r_ent;
        n_g      = r_g;
        n_want   = r_want;
        n_cnt    = r_cnt;
        n_k      = r_k;
        n_match  = r_match;
        n_emit   = r_emit;
        n_gkey   = r_gkey;
        o_cmd_pop  = 1'b0;
        key_we     = 1'b0;
        key_re     = 1'b0;
        key_waddr  = r_fill[IW-1:0];
        cnt_we     = 1'b0;
        cnt_re     = 1'b0;
        cnt_waddr  = r_fill[IW-1:0];
        cnt_wdata  = CW'(1);
        peer_we    = 1'b0;
        peer_re    = 1'b0;
        peer_waddr = PAW'(r_fill[IW-1:0]) * PAW'(MAX_PEERS);
        peer_wdata = r_cmd.addr;
        res_push   = 1'b0;
        res_data   = r_res;

        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_i       = '0;
                    n_pend    = 1'b0;
                    if (i_cmd.zero_key) begin
                        n_res.kind       = kptl_pkg::KIND_STATUS;
                        n_res.status     = kptl_pkg::ST_ZERO_KEY;
                        n_res.group      = 2'd0;
                        n_res.key_out    = i_cmd.key;
                        n_res.peer_out   = i_cmd.addr;
                        n_res.peer_count = 4'd0;
                        n_res.last       = 1'b1;
                        if (i_cmd.func == kptl_pkg::FUNC_LOOKUP) begin
                            n_res.kind     = kptl_pkg::KIND_HEADER;
                            n_res.status   = kptl_pkg::ST_NEW_ENTRY;
                            n_res.peer_out = 32'd0;
                        end
                        n_state = S_OUT1;
                    end else begin
                        n_state = S_SRCH;
                    end
                end
            end
            S_SRCH: begin
                if (match) begin
                    n_ent  = r_pidx;
                    n_g    = 2'd0;
                    n_want = (r_cmd.func == kptl_pkg::FUNC_LOOKUP) ? want : 2'd0;
                    n_state = S_RREAD;
                end else if (r_i < r_fill) begin
                    key_re = 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_i[IW-1:0];
                    n_i    = r_i + 1'b1;
                end else begin
                    n_res.group    = 2'd0;
                    n_res.key_out  = r_cmd.key;
                    n_res.last     = 1'b1;
                    if (r_cmd.func == kptl_pkg::FUNC_LOOKUP) begin
                        n_res.kind       = kptl_pkg::KIND_HEADER;
                        n_res.status     = kptl_pkg::ST_NEW_ENTRY;
                        n_res.peer_out   = 32'd0;
                        n_res.peer_count = 4'd0;
                    end else if (r_fill >= FW'(TABLE_ENTRIES)) begin
                        n_res.kind       = kptl_pkg::KIND_STATUS;
                        n_res.status     = kptl_pkg::ST_TABLE_FULL;
                        n_res.peer_out   = r_cmd.addr;
                        n_res.peer_count = 4'd0;
                    end else begin
                        key_we  = 1'b1;
                        cnt_we  = 1'b1;
                        peer_we = 1'b1;
                        n_fill  = r_fill + 1'b1;
                        n_res.kind       = kptl_pkg::KIND_STATUS;
                        n_res.status     = kptl_pkg::ST_NEW_ENTRY;
                        n_res.peer_out   = r_cmd.addr;
                        n_res.peer_count = 4'd1;
                    end
                    n_state = S_OUT1;
                end
            end
            S_RREAD: begin
                key_re  = 1'b1;
                cnt_re  = 1'b1;
                n_state = S_RCAP;
            end
            S_RCAP: begin
                n_cnt   = (cnt_rdata > CW'(MAX_PEERS)) ? CW'(MAX_PEERS) : cnt_rdata;
                n_gkey  = key_rdata;
                n_k     = '0;
                n_match = '0;
                n_state = (cnt_rdata == '0) ? S_SDONE : S_CRD;
            end
            S_CRD: begin
                peer_re = 1'b1;
                n_state = S_CCMP;
            end
            S_CCMP: begin
                if (peer_rdata == cmp_val) begin
                    n_match = r_match + 1'b1;
                end
                n_k     = r_k + 1'b1;
                n_state = ((r_k + 1'b1) == r_cnt) ? S_SDONE : S_CRD;
            end
            S_SDONE: begin
                if (r_cmd.func == kptl_pkg::FUNC_LOOKUP) begin
                    n_state = S_HDR;
                end else begin
                    n_res.kind       = kptl_pkg::KIND_STATUS;
                    n_res.group      = 2'd0;
                    n_res.key_out    = r_cmd.key;
                    n_res.peer_out   = r_cmd.addr;
                    n_res.peer_count = 4'(r_cnt);
                    n_res.last       = 1'b1;
                    if (r_match != '0) begin
                        n_res.status = kptl_pkg::ST_DUPLICATE;
                    end else if (r_cnt >= CW'(MAX_PEERS)) begin
                        n_res.status = kptl_pkg::ST_PEERS_FULL;
                    end else begin
                        cnt_we     = 1'b1;
                        cnt_waddr  = r_ent;
                        cnt_wdata  = r_cnt + 1'b1;
                        peer_we    = 1'b1;
                        peer_waddr = PAW'(r_ent) * PAW'(MAX_PEERS) + PAW'(r_cnt);
                        n_res.status     = kptl_pkg::ST_PEER_ADDED;
                        n_res.peer_count = 4'(r_cnt + 1'b1);
                    end
                    n_state = S_OUT1;
                end
            end
            S_HDR: begin
                res_data.kind       = kptl_pkg::KIND_HEADER;
                res_data.status     = kptl_pkg::ST_NEW_ENTRY;
                res_data.group      = r_g;
                res_data.key_out    = r_gkey;
                res_data.peer_out   = 32'd0;
                res_data.peer_count = 4'(kept);
                res_data.last       = last_grp && (kept == '0);
                if (!res_full) begin
                    res_push = 1'b1;
                    n_k      = '0;
                    n_emit   = '0;
                    n_state  = (kept == '0) ? S_NEXTG : S_PRD;
                end
            end
            S_PRD: begin
                peer_re = 1'b1;
                n_state = S_PEM;
            end
            S_PEM: begin
                res_data.kind       = kptl_pkg::KIND_PEER;
                res_data.status     = kptl_pkg::ST_NEW_ENTRY;
                res_data.group      = r_g;
                res_data.key_out    = r_gkey;
                res_data.peer_out   = peer_rdata;
                res_data.peer_count = 4'(kept);
                res_data.last       = last_grp && ((r_emit + 1'b1) == kept);
                if (skip || !res_full) begin
                    res_push = !skip;
                    if (!skip) begin
                        n_emit = r_emit + 1'b1;
                    end
                    n_k     = r_k + 1'b1;
                    n_state = ((r_k + 1'b1) == r_cnt) ? S_NEXTG : S_PRD;
                end
            end
            S_NEXTG: begin
                if (last_grp) begin
                    n_state = S_IDLE;
                end else begin
                    n_g     = r_g + 1'b1;
                    n_ent   = next_ent;
                    n_state = S_RREAD;
                end
            end
            S_OUT1: begin
                if (!res_full) begin
                    res_push = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_pc    <= 2'd2;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
            if (i_cfg_we) begin
                r_pc <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_res   <= n_res;
        r_i     <= n_i;
        r_pidx  <= n_pidx;
        r_ent   <= n_ent;
        r_g     <= n_g;
        r_want  <= n_want;
        r_cnt   <= n_cnt;
        r_k     <= n_k;
        r_match <= n_match;
        r_emit  <= n_emit;
        r_gkey  <= n_gkey;
    end

    kptl_ram #(
        .WIDTH (64),
        .DEPTH (TABLE_ENTRIES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (r_cmd.key),
        .i_re    (key_re),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    kptl_ram #(
        .WIDTH (CW),
        .DEPTH (TABLE_ENTRIES)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (r_ent),
        .o_rdata (cnt_rdata)
    );

    kptl_ram #(
        .WIDTH (32),
        .DEPTH (PD)
    ) u_peer_ram (
        .i_clk   (i_clk),
        .i_we    (peer_we),
        .i_waddr (peer_waddr),
        .i_wdata (peer_wdata),
        .i_re    (peer_re),
        .i_raddr (peer_raddr),
        .o_rdata (peer_rdata)
    );

    kptl_fifo #(
        .WIDTH ($bits(kptl_pkg::t_res)),
        .DEPTH (kptl_pkg::RES_QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_data),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (o_res),
        .o_empty (o_empty)
    );

endmodule

`default_nettype wire

// ===== rtl/core/key_peer_table_lookup.sv =====
// A request is taken from the command queue once the engine is idle, and the
// key search then reads one table entry per cycle over the filled entries.
// Each reported group takes a count pass and an emit pass over its peer list;
// the emit pass waits while the result queue is full.
// One request is worked on at a time; up to two more wait in the command queue.
// Synchronous reset empties the table and both queues and sets the count to 2.
// ----------------------------------------------------------------------------
// key_peer_table_lookup
// Table of 64-bit keys with peer address sets, with register and lookup
// requests.
// ----------------------------------------------------------------------------
`default_nettype none

module key_peer_table_lookup #(
    parameter int TABLE_ENTRIES = kptl_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_PEERS     = kptl_pkg::MAX_PEERS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_wdata,
    input  wire logic           push,
    input  wire kptl_pkg::t_req i_req,
    output logic                full,
    output logic                empty,
    input  wire logic           pop,
    output kptl_pkg::t_res      o_res
);

    kptl_pkg::t_cmd cmd;
    logic           cmd_empty;
    logic           cmd_pop;

    kptl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_req       (i_req),
        .o_full      (full),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd),
        .o_cmd_empty (cmd_empty)
    );

    kptl_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_PEERS     (MAX_PEERS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res       (o_res),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule

`default_nettype wire

// ===== rtl/core/kptl_checker.sv =====
// ----------------------------------------------------------------------------
// kptl_checker
// Port-level checks of the key peer table lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

module kptl_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           empty,
    input wire logic           pop,
    input wire kptl_pkg::t_res o_res
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_res)))
        else $error("waiting result changed");

    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.kind == kptl_pkg::KIND_STATUS) |->
        (o_res.last && o_res.group == 2'd0))
        else $error("status result is not a single final result");

    a_header_peers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.kind == kptl_pkg::KIND_HEADER && o_res.peer_count != 4'd0) |->
        !o_res.last)
        else $error("header with peers marked final");

    a_new_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.kind == kptl_pkg::KIND_STATUS &&
         o_res.status == kptl_pkg::ST_NEW_ENTRY) |-> (o_res.peer_count == 4'd1))
        else $error("new entry does not hold exactly one peer");

endmodule

bind key_peer_table_lookup kptl_checker u_kptl_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .o_res   (o_res)
);

`default_nettype wire
